@@ hdl/scd_pkg.sv @@
// Package for the stable-change detector: link mode codes, register indexes
// and the link configuration struct. No dependencies.
package scd_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_STABLE_TIME   = 3'd0;
    localparam logic [2:0] CFG_MIN_VARIATION = 3'd1;
    localparam logic [2:0] CFG_FULL_SCALE    = 3'd2;
    localparam logic [2:0] CFG_LINK_MODE     = 3'd3;
    localparam logic [2:0] CFG_NOTIFY_EN     = 3'd4;

    // Link mode codes; six and seven behave as no link
    localparam logic [2:0] LINK_NONE        = 3'd0;
    localparam logic [2:0] LINK_COPY        = 3'd1;
    localparam logic [2:0] LINK_NEGATE      = 3'd2;
    localparam logic [2:0] LINK_TOGGLE      = 3'd3;
    localparam logic [2:0] LINK_TOGGLE_HIGH = 3'd4;
    localparam logic [2:0] LINK_TOGGLE_LOW  = 3'd5;

    // Output link settings handed to the core
    typedef struct packed {
        logic [2:0] mode;
        logic       notify_en;
    } t_link_cfg;

endpackage

@@ hdl/scd_core.sv @@
// Change detection core: held value, timestamp and output level state, plus
// the single-pass acceptance logic. Depends on scd_pkg.
module scd_core import scd_pkg::*; #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [TIME_BITS-1:0]   i_now_ms,
    input  logic [TIME_BITS-1:0]   i_stable_time,
    input  logic [SAMPLE_BITS-1:0] i_min_variation,
    input  logic [SAMPLE_BITS-1:0] i_full_scale,
    input  t_link_cfg              i_link,
    output logic                   o_notify,
    output logic [SAMPLE_BITS-1:0] o_accepted_value,
    output logic                   o_drive_update,
    output logic                   o_drive_level
);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = SAMPLE_BITS'(1);

    logic [SAMPLE_BITS-1:0] r_held_value, n_held_value;
    logic                   r_held_valid, n_held_valid;
    logic [TIME_BITS-1:0]   r_last_time,  n_last_time;
    logic                   r_out_level,  n_out_level;

    logic                   linked, active, differs, moved, elapsed, accept;
    logic [SAMPLE_BITS-1:0] diff;
    logic [TIME_BITS-1:0]   age;
    logic                   upd;

    // Candidate and stability tests
    always_comb begin
        linked  = (i_link.mode >= LINK_COPY) && (i_link.mode <= LINK_TOGGLE_LOW);
        active  = i_link.notify_en || linked;
        differs = !r_held_valid || (r_held_value != i_sample);
        diff    = (r_held_value > i_sample) ? (r_held_value - i_sample)
                                            : (i_sample - r_held_value);
        moved   = !r_held_valid || (diff >= i_min_variation)
                  || (i_sample == '0) || (i_sample == i_full_scale);
        age     = i_now_ms - r_last_time;
        elapsed = (age >= i_stable_time);
        accept  = active && differs && moved && elapsed;
    end

    // Next state and linked output drive
    always_comb begin
        n_held_value = r_held_value;
        n_held_valid = r_held_valid;
        n_last_time  = r_last_time;
        n_out_level  = r_out_level;
        upd          = 1'b0;
        if (accept) begin
            n_held_value = i_sample;
            n_held_valid = 1'b1;
            n_last_time  = i_now_ms;
            unique case (i_link.mode)
                LINK_COPY: begin
                    n_out_level = (i_sample != '0);
                    upd         = 1'b1;
                end
                LINK_NEGATE: begin
                    n_out_level = (i_sample != SAMPLE_ONE);
                    upd         = 1'b1;
                end
                LINK_TOGGLE: begin
                    n_out_level = !r_out_level;
                    upd         = 1'b1;
                end
                LINK_TOGGLE_HIGH: begin
                    if (i_sample == SAMPLE_ONE) begin
                        n_out_level = !r_out_level;
                        upd         = 1'b1;
                    end
                end
                LINK_TOGGLE_LOW: begin
                    if (i_sample == '0) begin
                        n_out_level = !r_out_level;
                        upd         = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (active && !(differs && moved)) begin
            // equal or too small a move restarts the stability window
            n_last_time = i_now_ms;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_value <= '0;
            r_held_valid <= 1'b0;
            r_last_time  <= '0;
            r_out_level  <= 1'b0;
        end else if (i_step) begin
            r_held_value <= n_held_value;
            r_held_valid <= n_held_valid;
            r_last_time  <= n_last_time;
            r_out_level  <= n_out_level;
        end
    end

    // Result fields after this item
    assign o_notify         = accept && i_link.notify_en;
    assign o_accepted_value = n_held_value;
    assign o_drive_update   = upd;
    assign o_drive_level    = n_out_level;

endmodule

@@ hdl/stable_change_detector_with_output_link.sv @@
// Stable-change detector with linked digital output, top level.
// Beats pass the input register, then the result register. Throughput: one beat per
// cycle while i_m_tready is high; the only loop is the state update in scd_core.
// Reset (i_rst_n low, synchronous): registers to defaults, full scale all ones
// up to 4095, nothing held, output low, both pipeline stages emptied.
module stable_change_detector_with_output_link import scd_pkg::*; #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [((TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS)-1:0] i_cfg_data,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    // tdata: sample, now_ms, zero padding
    input  logic [((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    // tdata: notify, accepted_value, drive_update, drive_level, zero padding
    output logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int IN_BITS  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
    localparam int RES_BITS = SAMPLE_BITS + 3;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RST = SAMPLE_BITS'(32'd4095);

    logic [TIME_BITS-1:0]   r_stable_time;
    logic [SAMPLE_BITS-1:0] r_min_variation;
    logic [SAMPLE_BITS-1:0] r_full_scale;
    t_link_cfg              r_link;

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic [TIME_BITS-1:0]   r_in_now;

    logic                   r_out_valid;
    logic [RES_BITS-1:0]    r_out_data;

    logic                   advance, step, in_beat;
    logic                   c_notify, c_upd, c_level;
    logic [SAMPLE_BITS-1:0] c_value;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_time    <= '0;
            r_min_variation  <= '0;
            r_full_scale     <= FULL_SCALE_RST;
            r_link.mode      <= LINK_NONE;
            r_link.notify_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STABLE_TIME:   r_stable_time   <= i_cfg_data[TIME_BITS-1:0];
                CFG_MIN_VARIATION: r_min_variation <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_FULL_SCALE:    r_full_scale    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_LINK_MODE:     r_link.mode     <= i_cfg_data[2:0];
                CFG_NOTIFY_EN:     r_link.notify_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: both stages move together when the result slot is free; an empty input register also takes a beat
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign in_beat    = i_s_tvalid && o_s_tready;
    assign step       = r_in_valid && advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_sample <= i_s_tdata[SAMPLE_BITS-1:0];
            r_in_now    <= i_s_tdata[SAMPLE_BITS +: TIME_BITS];
        end
    end

    scd_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_sample         (r_in_sample),
        .i_now_ms         (r_in_now),
        .i_stable_time    (r_stable_time),
        .i_min_variation  (r_min_variation),
        .i_full_scale     (r_full_scale),
        .i_link           (r_link),
        .o_notify         (c_notify),
        .o_accepted_value (c_value),
        .o_drive_update   (c_upd),
        .o_drive_level    (c_level)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {c_level, c_upd, c_value, c_notify};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'(r_out_data);

    // input padding bits are ignored
    logic unused_pad;
    assign unused_pad = ^i_s_tdata[IN_BITS-1:0];

endmodule
